// File: src/assert_macros.svh
// Assertion macros shared by the NDVI hex binning RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: src/nhb_pkg.sv
// Shared types, constants and control structs of the NDVI hex binning block.
`timescale 1ns / 1ps
`default_nettype none
package nhb_pkg;

  localparam int HEX_SLOTS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int SLOT_W      = (HEX_SLOTS > 1) ? $clog2(HEX_SLOTS) : 1;

  localparam int DIVIDEND_W = 42;
  localparam int DIVISOR_W  = 25;
  localparam int STEP_W     = 6;
  localparam int PIX_NUM_W  = 34;
  localparam logic [STEP_W-1:0] PIX_STEPS  = STEP_W'(PIX_NUM_W);
  localparam logic [STEP_W-1:0] WIDE_STEPS = STEP_W'(DIVIDEND_W);

  localparam int FRAC = 25;
  localparam int CW   = 50;
  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
  localparam logic [15:0] SAMPLE_MASK =
    (SAMPLE_BITS >= 16) ? 16'hFFFF : 16'((1 << SAMPLE_BITS) - 1);

  // Register indexes of the configuration port
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Q_PER_COL        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Q_PER_ROW        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_R_PER_ROW        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CANOPY_THRESHOLD = 3'd5;

  localparam logic [12:0] RST_TILE_WIDTH  = 13'd100;
  localparam logic [12:0] RST_TILE_HEIGHT = 13'd100;
  localparam logic signed [31:0] RST_Q_PER_COL = 32'sd19370;
  localparam logic signed [31:0] RST_Q_PER_ROW = -32'sd11185;
  localparam logic signed [31:0] RST_R_PER_ROW = 32'sd22370;
  localparam logic signed [15:0] RST_CANOPY_THRESHOLD = 16'sd16384;

  typedef struct packed {
    logic [15:0] red_reflectance;
    logic [15:0] nir_reflectance;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] hex_q;
    logic signed [15:0] hex_r;
    logic signed [15:0] avg_ndvi;
    logic [15:0]        canopy_share;
    logic [23:0]        pixel_count;
    logic               table_overflow;
    logic               last_record;
  } record_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_SUMS, ST_ROUND, ST_ERR, ST_CUBE,
    ST_SEARCH, ST_DIVWAIT, ST_UPDATE, ST_SCAN, ST_MEAN_WAIT, ST_FRAC_WAIT,
    ST_PUSH, ST_CLEAR
  } state_t;

  typedef enum logic [3:0] {
    STEP_NONE, STEP_MUL0, STEP_MUL1, STEP_MUL2, STEP_SUMS, STEP_ROUND,
    STEP_ERR, STEP_CUBE, STEP_SEARCH, STEP_UPDATE
  } step_t;

  typedef enum logic [1:0] {
    DIV_PIX, DIV_MEAN, DIV_FRAC
  } div_sel_t;

  typedef struct packed {
    logic     load_pixel;
    step_t    step;
    logic     div_start;
    div_sel_t div_sel;
    logic     mean_capture;
    logic     idx_clear;
    logic     idx_inc;
    logic     out_load;
    logic     tile_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last_pixel;
    logic slot_at_idx;
    logic idx_at_end;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: src/ndvi_hex_bin_accumulator.sv
// Top level of the NDVI hex binning accumulator.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Pixels of a tile arrive in raster order; each one is binned into an axial
// hex cell of a 16-slot table that sums NDVI and counts pixels and canopy
// pixels. Each pixel's NDVI comes from the shared bit-serial divider in 34
// steps, while the hex mapping runs in parallel on one shared multiplier.
// After the tile's last pixel, each occupied slot yields one record in slot
// order from its two 42-step divisions (mean and canopy fraction), skipping
// empty slots; the table then clears. The record output is registered,
// so the next tile's first pixel is taken while the final record still waits.
// Configuration writes are always ready and must come while the block is idle.
module ndvi_hex_bin_accumulator import nhb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  pixel_t                 pixel,
  output logic                   record_valid,
  input  logic                   record_stall,
  output record_t                record,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  nhb_controller u_controller (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .status      (status),
    .cmd         (cmd)
  );

  nhb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .pixel        (pixel),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .record       (record),
    .record_valid (record_valid),
    .record_stall (record_stall)
  );

  // One pixel in flight at a time
  `ASSERT_CLK(a_one_pixel, (pixel_valid && !pixel_stall) |=> pixel_stall, "second pixel taken while busy")
  // The divider is idle whenever a pixel can be taken
  `ASSERT_CLK(a_div_idle, !pixel_stall |-> !status.div_busy, "divider busy while ready for a pixel")
  // Records describe occupied cells
  `ASSERT_CLK(a_count_nonzero, record_valid |-> (record.pixel_count != 24'd0), "record with empty cell")
  // Reset empties the output register
  `ASSERT_ALWAYS(a_reset_out, rst |=> !record_valid, "record valid after reset")

endmodule
`default_nettype wire

// File: src/nhb_divider.sv
// Bit-serial restoring divider shared by the NDVI and record arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module nhb_divider import nhb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  input  logic [STEP_W-1:0]     steps,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [DIVISOR_W:0]   rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [STEP_W-1:0]    left;
  logic [DIVISOR_W:0]   rem_shift;
  logic [DIVISOR_W:0]   rem_diff;
  logic                 take;

  // Trial subtract of one quotient bit
  always_comb begin
    rem_shift = {rem[DIVISOR_W-1:0], quotient[DIVIDEND_W-1]};
    rem_diff  = rem_shift - {1'b0, dsr};
    take      = (rem_shift >= {1'b0, dsr});
  end

  // Count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
    end else if (start) begin
      busy <= 1'b1;
      left <= steps;
    end else if (busy) begin
      left <= left - STEP_W'(1);
      if (left == STEP_W'(1)) busy <= 1'b0;
    end
  end

  // Shift the dividend through, one bit each cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? rem_diff : rem_shift;
      quotient <= {quotient[DIVIDEND_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

// File: src/nhb_datapath.sv
// Datapath: config registers, hex mapping, slot table, divider and output register.
`timescale 1ns / 1ps
`default_nettype none
module nhb_datapath import nhb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  pixel_t                 pixel,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  output record_t                record,
  output logic                   record_valid,
  input  logic                   record_stall
);

  localparam logic [CW-1:0] ROUND_HALF = CW'(1) << (FRAC - 1);

  function automatic logic [CW-1:0] abs_cw(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  function automatic logic signed [24:0] round_fix(input logic signed [CW-1:0] v);
    logic [CW-1:0] mag_v;
    logic [CW-1:0] sh;
    mag_v = abs_cw(v);
    sh    = (mag_v + ROUND_HALF) >> FRAC;
    return v[CW-1] ? -$signed(sh[24:0]) : $signed(sh[24:0]);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767) return 16'sd32767;
    if (v < -26'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Configuration registers
  logic [12:0]        tile_width, tile_height;
  logic signed [31:0] q_per_col, q_per_row, r_per_row;
  logic signed [15:0] canopy_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width       <= RST_TILE_WIDTH;
      tile_height      <= RST_TILE_HEIGHT;
      q_per_col        <= RST_Q_PER_COL;
      q_per_row        <= RST_Q_PER_ROW;
      r_per_row        <= RST_R_PER_ROW;
      canopy_threshold <= RST_CANOPY_THRESHOLD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TILE_WIDTH:       tile_width       <= cfg_data[12:0];
        REG_TILE_HEIGHT:      tile_height      <= cfg_data[12:0];
        REG_Q_PER_COL:        q_per_col        <= cfg_data;
        REG_Q_PER_ROW:        q_per_row        <= cfg_data;
        REG_R_PER_ROW:        r_per_row        <= cfg_data;
        REG_CANOPY_THRESHOLD: canopy_threshold <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Clamp tile size to 1..4096
  logic [12:0] w_eff, h_eff;
  always_comb begin
    w_eff = (tile_width == '0) ? 13'd1 : (tile_width > 13'd4096) ? 13'd4096 : tile_width;
    h_eff = (tile_height == '0) ? 13'd1 : (tile_height > 13'd4096) ? 13'd4096 : tile_height;
  end

  // Raster position and tile status
  logic [11:0] col_pos, row_pos;
  logic        overflow_seen;
  logic        col_end, row_end;
  assign col_end = ({1'b0, col_pos} >= (w_eff - 13'd1));
  assign row_end = ({1'b0, row_pos} >= (h_eff - 13'd1));

  // Latched pixel and NDVI operands
  logic [15:0] red_r, nir_r;
  logic        num_neg, den_zero;
  logic [15:0] num_mag;
  logic [16:0] den;
  logic [PIX_NUM_W-1:0] pix_num;

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      red_r <= pixel.red_reflectance & SAMPLE_MASK;
      nir_r <= pixel.nir_reflectance & SAMPLE_MASK;
    end
  end

  always_comb begin
    num_neg  = (nir_r < red_r);
    num_mag  = num_neg ? (red_r - nir_r) : (nir_r - red_r);
    den      = {1'b0, nir_r} + {1'b0, red_r};
    den_zero = (den == '0);
    pix_num  = {2'b00, num_mag, 16'h0000} + PIX_NUM_W'(den);
  end

  // Half-pixel offsets from tile center
  logic signed [13:0] offc, offr;
  assign offc = $signed({1'b0, col_pos, 1'b0}) - $signed({1'b0, w_eff});
  assign offr = $signed({1'b0, row_pos, 1'b0}) - $signed({1'b0, h_eff});

  // Shared coefficient multiplier
  logic signed [31:0] mul_a;
  logic signed [13:0] mul_b;
  logic signed [45:0] prod;
  always_comb begin
    unique case (cmd.step)
      STEP_MUL0: begin mul_a = q_per_col; mul_b = offc; end
      STEP_MUL1: begin mul_a = q_per_row; mul_b = offr; end
      default:   begin mul_a = r_per_row; mul_b = offr; end
    endcase
    prod = mul_a * mul_b;
  end

  // Coordinate pipeline registers
  logic signed [45:0] p0, p1;
  logic signed [CW-1:0] qv, rv, sv;
  logic signed [24:0] rq, rr, rs;
  logic [25:0] dq, dr, ds;
  logic signed [15:0] cell_q, cell_r;
  logic signed [25:0] rq_x, rr_x, rs_x, q_fix, r_fix;
  logic [CW-1:0] dq_full, dr_full, ds_full;

  // Rounding error of each axis
  always_comb begin
    dq_full = abs_cw($signed({rq, {FRAC{1'b0}}}) - qv);
    dr_full = abs_cw($signed({rr, {FRAC{1'b0}}}) - rv);
    ds_full = abs_cw($signed({rs, {FRAC{1'b0}}}) - sv);
  end

  always_comb begin
    rq_x  = {rq[24], rq};
    rr_x  = {rr[24], rr};
    rs_x  = {rs[24], rs};
    q_fix = rq_x;
    r_fix = rr_x;
    // Recompute the axis with the largest rounding error
    priority if (dq > dr && dq > ds) begin
      q_fix = -rr_x - rs_x;
    end else if (dr > ds) begin
      r_fix = -rq_x - rs_x;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      STEP_MUL0: p0 <= prod;
      STEP_MUL1: p1 <= prod;
      STEP_MUL2: begin
        rv <= CW'(prod);
        qv <= CW'(p0) + CW'(p1);
      end
      STEP_SUMS: sv <= -qv - rv;
      STEP_ROUND: begin
        rq <= round_fix(qv);
        rr <= round_fix(rv);
        rs <= round_fix(sv);
      end
      STEP_ERR: begin
        dq <= dq_full[25:0];
        dr <= dr_full[25:0];
        ds <= ds_full[25:0];
      end
      STEP_CUBE: begin
        cell_q <= sat16(q_fix);
        cell_r <= sat16(r_fix);
      end
      default: ;
    endcase
  end

  // Slot table
  logic [HEX_SLOTS-1:0] slot_valid;
  logic signed [15:0] slot_q [HEX_SLOTS];
  logic signed [15:0] slot_r [HEX_SLOTS];
  logic signed [39:0] ndvi_total [HEX_SLOTS];
  logic [23:0] count_all [HEX_SLOTS];
  logic [23:0] count_canopy [HEX_SLOTS];

  // Parallel match and first free slot
  logic              hit, free;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = HEX_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_q[i] == cell_q && slot_r[i] == cell_r) begin
        hit = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  logic [SLOT_W-1:0] idx;
  logic              cell_hit, cell_drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.step == STEP_SEARCH) begin
      idx <= hit ? hit_idx : free_idx;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == STEP_SEARCH) begin
      cell_hit  <= hit;
      cell_drop <= !hit && !free;
    end
  end

  // Divider quotient shared by all three divisions
  logic                  div_busy;
  logic [DIVIDEND_W-1:0] quotient;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [STEP_W-1:0]     div_steps;

  // Pixel NDVI from the quotient
  logic signed [15:0] ndvi_val;
  logic [16:0]        qmag;
  always_comb begin
    qmag = quotient[16:0];
    if (den_zero) ndvi_val = '0;
    else if (num_neg) ndvi_val = 16'(-$signed({1'b0, qmag}));
    else if (qmag > 17'd32767) ndvi_val = 16'sd32767;
    else ndvi_val = qmag[15:0];
  end

  // Accumulate into the chosen slot
  logic signed [39:0] base_sum;
  logic [23:0]        base_cnt, base_can;
  always_comb begin
    base_sum = cell_hit ? ndvi_total[idx] : '0;
    base_cnt = cell_hit ? count_all[idx] : '0;
    base_can = cell_hit ? count_canopy[idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.step == STEP_UPDATE && !cell_drop) begin
      slot_q[idx] <= cell_q;
      slot_r[idx] <= cell_r;
      if (base_cnt < COUNT_MAX) begin
        ndvi_total[idx]   <= base_sum + 40'(ndvi_val);
        count_all[idx]    <= base_cnt + 24'd1;
        count_canopy[idx] <= base_can + ((ndvi_val > canopy_threshold) ? 24'd1 : 24'd0);
      end else begin
        ndvi_total[idx]   <= base_sum;
        count_all[idx]    <= base_cnt;
        count_canopy[idx] <= base_can;
      end
    end
  end

  // Valid bits, position and overflow flag
  always_ff @(posedge clk) begin
    if (rst || cmd.tile_clear) begin
      slot_valid    <= '0;
      col_pos       <= '0;
      row_pos       <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.step == STEP_UPDATE) begin
      if (cell_drop) overflow_seen <= 1'b1;
      else slot_valid[idx] <= 1'b1;
      if (!(col_end && row_end)) begin
        if (col_end) begin
          col_pos <= '0;
          row_pos <= row_pos + 12'd1;
        end else begin
          col_pos <= col_pos + 12'd1;
        end
      end
    end
  end

  // Record operands for the slot at idx
  logic signed [39:0] cur_sum;
  logic [39:0]        sum_mag;
  logic [23:0]        cnt_eff;
  logic [DIVIDEND_W-1:0] mean_num, frac_num;
  always_comb begin
    cur_sum  = ndvi_total[idx];
    sum_mag  = cur_sum[39] ? 40'(-cur_sum) : 40'(cur_sum);
    cnt_eff  = (count_all[idx] == '0) ? 24'd1 : count_all[idx];
    mean_num = {1'b0, sum_mag, 1'b0} + DIVIDEND_W'(cnt_eff);
    frac_num = {1'b0, count_canopy[idx], 17'h00000} + DIVIDEND_W'(cnt_eff);
  end

  // Divider operand select
  always_comb begin
    unique case (cmd.div_sel)
      DIV_MEAN: begin
        div_dividend = mean_num;
        div_divisor  = {cnt_eff, 1'b0};
        div_steps    = WIDE_STEPS;
      end
      DIV_FRAC: begin
        div_dividend = frac_num;
        div_divisor  = {cnt_eff, 1'b0};
        div_steps    = WIDE_STEPS;
      end
      default: begin
        div_dividend = {pix_num, {(DIVIDEND_W - PIX_NUM_W){1'b0}}};
        div_divisor  = DIVISOR_W'({den, 1'b0});
        div_steps    = PIX_STEPS;
      end
    endcase
  end

  nhb_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Hold the signed, saturated mean
  logic signed [15:0] mean_r;
  always_ff @(posedge clk) begin
    if (cmd.mean_capture) begin
      if (cur_sum[39]) begin
        mean_r <= (quotient > DIVIDEND_W'(32768)) ? -16'sd32768
                : 16'(-$signed({1'b0, quotient[15:0]}));
      end else begin
        mean_r <= (quotient > DIVIDEND_W'(32767)) ? 16'sd32767 : quotient[15:0];
      end
    end
  end

  // Any occupied slot after idx
  logic later_valid;
  always_comb begin
    later_valid = 1'b0;
    for (int i = 0; i < HEX_SLOTS; i++) begin
      if (i > int'(idx) && slot_valid[i]) later_valid = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (cmd.out_load) begin
      record_valid <= 1'b1;
    end else if (!record_stall) begin
      record_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      record.hex_q          <= slot_q[idx];
      record.hex_r          <= slot_r[idx];
      record.avg_ndvi       <= mean_r;
      record.canopy_share   <= (quotient > DIVIDEND_W'(65535)) ? 16'hFFFF : quotient[15:0];
      record.pixel_count    <= count_all[idx];
      record.table_overflow <= overflow_seen;
      record.last_record    <= !later_valid;
    end
  end

  // Status to the controller
  always_comb begin
    status.div_busy    = div_busy;
    status.last_pixel  = col_end && row_end;
    status.slot_at_idx = slot_valid[idx];
    status.idx_at_end  = (idx == SLOT_W'(HEX_SLOTS - 1));
    status.out_free    = !record_valid || !record_stall;
  end

endmodule
`default_nettype wire

// File: src/nhb_controller.sv
// Controller state machine sequencing pixel binning and record emission.
`timescale 1ns / 1ps
`default_nettype none
module nhb_controller import nhb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    pixel_stall = 1'b1;
    cmd         = '0;
    cmd.step    = STEP_NONE;
    cmd.div_sel = DIV_PIX;
    unique case (state)
      ST_IDLE: begin
        pixel_stall = 1'b0;
        if (pixel_valid) begin
          cmd.load_pixel = 1'b1;
          state_next = ST_MUL0;
        end
      end
      ST_MUL0: begin
        cmd.step = STEP_MUL0;
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_PIX;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.step = STEP_MUL1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.step = STEP_MUL2;
        state_next = ST_SUMS;
      end
      ST_SUMS: begin
        cmd.step = STEP_SUMS;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.step = STEP_ROUND;
        state_next = ST_ERR;
      end
      ST_ERR: begin
        cmd.step = STEP_ERR;
        state_next = ST_CUBE;
      end
      ST_CUBE: begin
        cmd.step = STEP_CUBE;
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd.step = STEP_SEARCH;
        state_next = ST_DIVWAIT;
      end
      ST_DIVWAIT: begin
        if (!status.div_busy) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.step = STEP_UPDATE;
        if (status.last_pixel) begin
          cmd.idx_clear = 1'b1;
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        priority if (status.slot_at_idx) begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_MEAN;
          state_next = ST_MEAN_WAIT;
        end else if (status.idx_at_end) begin
          state_next = ST_CLEAR;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_MEAN_WAIT: begin
        cmd.div_sel = DIV_MEAN;
        if (!status.div_busy) begin
          cmd.mean_capture = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel = DIV_FRAC;
          state_next = ST_FRAC_WAIT;
        end
      end
      ST_FRAC_WAIT: begin
        if (!status.div_busy) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.idx_at_end) begin
            state_next = ST_CLEAR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        cmd.tile_clear = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the NDVI hex binning accumulator.
`timescale 1ns / 1ps
`default_nettype none
module testbench import nhb_pkg::*; ();

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
  localparam int DRAIN_CYCLES = 1600;

  // Predicts cell records from accepted pixels and checks the records that come out
  class hex_bin_scoreboard;
    logic [12:0]        width_reg, height_reg;
    logic signed [31:0] qcol_reg, qrow_reg, rrow_reg;
    logic signed [15:0] thresh_reg;
    bit                 used[HEX_SLOTS];
    longint             cell_q[HEX_SLOTS], cell_r[HEX_SLOTS], cell_sum[HEX_SLOTS];
    longint             cell_cnt[HEX_SLOTS], cell_canopy[HEX_SLOTS];
    longint             col, row;
    bit                 ovf;
    record_t            pending[$];
    int                 mismatches, records_seen, tiles_done, overflow_tiles;

    function new();
      width_reg  = RST_TILE_WIDTH;
      height_reg = RST_TILE_HEIGHT;
      qcol_reg   = RST_Q_PER_COL;
      qrow_reg   = RST_Q_PER_ROW;
      rrow_reg   = RST_R_PER_ROW;
      thresh_reg = RST_CANOPY_THRESHOLD;
      clear_cells();
    endfunction

    function void clear_cells();
      for (int i = 0; i < HEX_SLOTS; i++) used[i] = 0;
      col = 0;
      row = 0;
      ovf = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_TILE_WIDTH:       width_reg  = d[12:0];
        REG_TILE_HEIGHT:      height_reg = d[12:0];
        REG_Q_PER_COL:        qcol_reg   = d;
        REG_Q_PER_ROW:        qrow_reg   = d;
        REG_R_PER_ROW:        rrow_reg   = d;
        REG_CANOPY_THRESHOLD: thresh_reg = d[15:0];
        default: ;
      endcase
    endfunction

    function longint size_of(logic [12:0] v);
      if (v == 0) return 1;
      if (v > 4096) return 4096;
      return v;
    endfunction

    function longint round25(longint v);
      longint half;
      half = longint'(1) <<< (FRAC - 1);
      if (v >= 0) return (v + half) >>> FRAC;
      return -((-v + half) >>> FRAC);
    endfunction

    function longint abs_l(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_pixel(pixel_t p);
      longint red, nir, num, den, ndvi, w, h, offc, offr, qv, rv, sv, one;
      longint rq, rr, rs, dq, dr, ds, cnt, mean, frac;
      int slot, n;
      record_t rec;
      red = p.red_reflectance & SAMPLE_MASK;
      nir = p.nir_reflectance & SAMPLE_MASK;
      w = size_of(width_reg);
      h = size_of(height_reg);
      // NDVI in Q1.15, zero when both bands are dark
      num = nir - red;
      den = nir + red;
      if (den == 0) ndvi = 0;
      else begin
        ndvi = (abs_l(num) * 65536 + den) / (2 * den);
        if (num < 0) ndvi = -ndvi;
        else if (ndvi > 32767) ndvi = 32767;
      end
      // map half-pixel offsets to fractional axial coordinates, cube-round
      offc = 2 * col - w;
      offr = 2 * row - h;
      qv = longint'(qcol_reg) * offc + longint'(qrow_reg) * offr;
      rv = longint'(rrow_reg) * offr;
      sv = -qv - rv;
      one = longint'(1) <<< FRAC;
      rq = round25(qv);
      rr = round25(rv);
      rs = round25(sv);
      dq = abs_l(rq * one - qv);
      dr = abs_l(rr * one - rv);
      ds = abs_l(rs * one - sv);
      if (dq > dr && dq > ds) rq = -rr - rs;
      else if (dr > ds) rr = -rq - rs;
      rq = sat16(rq);
      rr = sat16(rr);
      // find the cell, else take a free slot, else drop
      slot = -1;
      for (int i = 0; i < HEX_SLOTS; i++)
        if (slot < 0 && used[i] && cell_q[i] == rq && cell_r[i] == rr) slot = i;
      if (slot < 0) begin
        for (int i = 0; i < HEX_SLOTS; i++)
          if (slot < 0 && !used[i]) slot = i;
        if (slot >= 0) begin
          used[slot] = 1;
          cell_q[slot] = rq;
          cell_r[slot] = rr;
          cell_sum[slot] = 0;
          cell_cnt[slot] = 0;
          cell_canopy[slot] = 0;
        end else ovf = 1;
      end
      if (slot >= 0 && cell_cnt[slot] < COUNT_MAX) begin
        cell_sum[slot] += ndvi;
        cell_cnt[slot]++;
        if (ndvi > longint'(thresh_reg)) cell_canopy[slot]++;
      end
      // advance the raster position
      if (!(col >= w - 1 && row >= h - 1)) begin
        if (col >= w - 1) begin
          col = 0;
          row++;
        end else col++;
        return;
      end
      // end of tile: one record per occupied slot
      n = 0;
      for (int i = 0; i < HEX_SLOTS; i++) begin
        if (used[i]) begin
          cnt = (cell_cnt[i] == 0) ? 1 : cell_cnt[i];
          mean = (2 * abs_l(cell_sum[i]) + cnt) / (2 * cnt);
          if (cell_sum[i] < 0) mean = -mean;
          mean = sat16(mean);
          frac = (cell_canopy[i] * 131072 + cnt) / (2 * cnt);
          if (frac > 65535) frac = 65535;
          rec.hex_q = cell_q[i][15:0];
          rec.hex_r = cell_r[i][15:0];
          rec.avg_ndvi = mean[15:0];
          rec.canopy_share = frac[15:0];
          rec.pixel_count = cell_cnt[i][23:0];
          rec.table_overflow = ovf;
          rec.last_record = 0;
          pending = {pending, rec};
          n++;
        end
      end
      if (n > 0) pending[pending.size() - 1].last_record = 1;
      tiles_done++;
      if (ovf) overflow_tiles++;
      clear_cells();
    endfunction

    function void check_record(record_t got);
      record_t want;
      records_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record q=%0d r=%0d", got.hex_q, got.hex_r);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"record mismatch: expected q=%0d r=%0d mean=%0d frac=%0d cnt=%0d ",
                    "ovf=%0b last=%0b, got q=%0d r=%0d mean=%0d frac=%0d cnt=%0d ",
                    "ovf=%0b last=%0b"},
                   want.hex_q, want.hex_r, want.avg_ndvi, want.canopy_share,
                   want.pixel_count, want.table_overflow, want.last_record,
                   got.hex_q, got.hex_r, got.avg_ndvi, got.canopy_share,
                   got.pixel_count, got.table_overflow, got.last_record);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   pixel_valid;
  logic                   pixel_stall;
  pixel_t                 pixel;
  logic                   record_valid;
  logic                   record_stall;
  record_t                record;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_data;

  hex_bin_scoreboard sb;
  bit hold_req;
  int pixels_sent;

  ndvi_hex_bin_accumulator dut (
    .clk, .rst, .pixel_valid, .pixel_stall, .pixel, .record_valid, .record_stall,
    .record, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #8000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // Record receiver: random stall before each transaction, long hold on request
  initial begin
    int hold;
    record_stall = 1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = hold_req ? 500 : $urandom_range(0, 7);
      hold_req = 0;
      if (hold > 0) begin
        record_stall <= 1;
        repeat (hold) @(posedge clk);
      end
      record_stall <= 0;
      do @(posedge clk); while (!record_valid);
    end
  end

  // Record monitor
  always @(posedge clk) begin
    if (!rst && record_valid && !record_stall) sb.check_record(record);
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Size registers with random junk above the 13 used bits now and then
  task automatic write_size(logic [CFG_INDEX_W-1:0] idx, logic [12:0] v);
    logic [31:0] d;
    d = {19'd0, v};
    if ($urandom_range(0, 3) == 0) d[31:13] = 19'($urandom());
    write_reg(idx, d);
  endtask

  task automatic send_pixel(pixel_t p, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      pixel_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    pixel <= p;
    pixel_valid <= 1;
    do @(posedge clk); while (pixel_stall);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  // Hold until every expected record is out, then let the block settle
  task automatic drain();
    pixel_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    logic [31:0] c;
    case ($urandom_range(0, 5))
      0: c = $urandom();
      1: c = 32'sd33554432 >>> $urandom_range(0, 2);
      2: c = 32'h0000_0000;
      default: c = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    endcase
    if ($urandom_range(0, 1) == 0 && c != 0) c = -c;
    return c;
  endfunction

  task automatic run_tiles(int ntiles, bit no_gap);
    pixel_t p;
    longint n;
    n = sb.size_of(sb.width_reg) * sb.size_of(sb.height_reg) * ntiles;
    for (longint i = 0; i < n; i++) begin
      p.red_reflectance = rand_sample();
      p.nir_reflectance = rand_sample();
      send_pixel(p, no_gap);
    end
  endtask

  // Stimulus
  initial begin
    pixel_t dir_px[$];
    int phase;
    sb = new();
    rst = 1;
    pixel_valid = 0;
    pixel = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 0;
    pixels_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: one-pixel tiles over NDVI extremes, zero sum and saturation
    write_size(REG_TILE_WIDTH, 13'd0);
    write_size(REG_TILE_HEIGHT, 13'd0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    dir_px = '{'{16'h0000, 16'h0000}, '{16'hFFFF, 16'h0000}, '{16'h0000, 16'hFFFF},
               '{16'hFFFF, 16'hFFFF}, '{16'h0001, 16'h0000}, '{16'h0000, 16'h0001},
               '{16'h0001, 16'h0003}, '{16'h0003, 16'h0001}};
    foreach (dir_px[i]) send_pixel(dir_px[i], 0);
    drain();
    // Threshold extremes
    write_reg(REG_CANOPY_THRESHOLD, 32'h0000_8000);
    send_pixel('{16'hFFFF, 16'h0000}, 0);
    send_pixel('{16'h1234, 16'h1234}, 0);
    drain();
    write_reg(REG_CANOPY_THRESHOLD, 32'hFFFF_7FFF);
    send_pixel('{16'h0000, 16'hFFFF}, 0);
    drain();
    // Coefficient extremes on a 3x3 tile
    write_size(REG_TILE_WIDTH, 13'd3);
    write_size(REG_TILE_HEIGHT, 13'd3);
    write_reg(REG_Q_PER_COL, 32'h7FFF_FFFF);
    write_reg(REG_Q_PER_ROW, 32'h8000_0000);
    write_reg(REG_R_PER_ROW, 32'h8000_0000);
    run_tiles(1, 0);
    drain();

    // Full table: one hex per pixel on a 6x6 tile
    write_size(REG_TILE_WIDTH, 13'd6);
    write_size(REG_TILE_HEIGHT, 13'd6);
    write_reg(REG_Q_PER_COL, 32'h0200_0000);
    write_reg(REG_Q_PER_ROW, 32'h0000_0000);
    write_reg(REG_R_PER_ROW, 32'h0200_0000);
    write_reg(REG_CANOPY_THRESHOLD, 32'h0000_0000);
    run_tiles(1, 0);
    drain();

    // Backpressure: one-pixel tiles while the receiver holds off
    write_size(REG_TILE_WIDTH, 13'd1);
    write_size(REG_TILE_HEIGHT, 13'd1);
    hold_req = 1;
    run_tiles(40, 1);
    drain();

    // Random phases over sizes, coefficients and thresholds
    phase = 0;
    while (pixels_sent < 360) begin
      write_size(REG_TILE_WIDTH, 13'($urandom_range(0, 6)));
      write_size(REG_TILE_HEIGHT, 13'($urandom_range(0, 4)));
      write_reg(REG_Q_PER_COL, rand_coef());
      write_reg(REG_Q_PER_ROW, rand_coef());
      write_reg(REG_R_PER_ROW, rand_coef());
      write_reg(REG_CANOPY_THRESHOLD, $urandom());
      run_tiles($urandom_range(2, 4), phase % 3 == 0);
      if (phase % 4 == 3) drain();
      else begin
        pixel_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
      repeat (DRAIN_CYCLES) @(posedge clk);
      phase++;
    end

    $display("covered %0d pixels in %0d tiles (%0d with a full table), %0d records checked",
             pixels_sent, sb.tiles_done, sb.overflow_tiles, sb.records_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d records missing", sb.mismatches, sb.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
